@@ design/lmcmc_pkg.sv @@
// Shared constants and types for the LRU multi-cache miss counter.
// No dependencies; used by the interfaces, the stack cells and the top level.
package lmcmc_pkg;

	localparam int NUM_CACHES_DEF = 4;
	localparam int MAX_LINES_DEF  = 64;
	localparam int ADDR_BITS_DEF  = 24;

	// counter slots on the result port
	localparam int SLOTS      = 4;
	localparam int SLOT_W     = 3;
	localparam int SIZE_W     = 7;
	localparam int NUMC_W     = 3;
	localparam int CNT_W      = 32;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [REG_IDX_W-1:0] REG_NUM_CACHES   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CACHE_SIZE_0 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CACHE_SIZE_1 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CACHE_SIZE_2 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CACHE_SIZE_3 = 3'd4;

	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	localparam logic [NUMC_W-1:0] NUM_CACHES_RST = 3'd4;
	localparam logic [SIZE_W-1:0] CACHE_SIZE_RST = 7'd64;

	// control from the sequencer to the cell row
	typedef struct packed {
		logic encode;   // register the hit position
		logic shift;    // move entries down, insert new address at top
	} stack_ctrl_t;

endpackage

@@ design/lmcmc_if.sv @@
// Request and result channel interfaces (valid/ready plus payload).
// Depends on lmcmc_pkg.
interface lmcmc_req_if #(
	parameter int ADDR_W = lmcmc_pkg::ADDR_BITS_DEF
);
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output req_type, output address, input ready);
	modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface lmcmc_res_if;
	logic                         valid;
	logic                         ready;
	logic [lmcmc_pkg::SLOTS-1:0]  miss_mask;
	logic [lmcmc_pkg::CNT_W-1:0]  miss_count_0;
	logic [lmcmc_pkg::CNT_W-1:0]  miss_count_1;
	logic [lmcmc_pkg::CNT_W-1:0]  miss_count_2;
	logic [lmcmc_pkg::CNT_W-1:0]  miss_count_3;

	modport source (output valid, output miss_mask, output miss_count_0, output miss_count_1,
		output miss_count_2, output miss_count_3, input ready);
	modport sink   (input valid, input miss_mask, input miss_count_0, input miss_count_1,
		input miss_count_2, input miss_count_3, output ready);
endinterface

@@ design/lmcmc_cell.sv @@
// One recency stack cell: holds an address and its valid bit,
// compares against the broadcast address and takes its upper neighbor on a shift.
module lmcmc_cell #(
	parameter int ADDR_W = lmcmc_pkg::ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmp_en,
	input  logic [ADDR_W-1:0] cmp_addr,
	input  logic              shift_en,
	input  logic [ADDR_W-1:0] prev_data,
	input  logic              prev_valid,
	output logic [ADDR_W-1:0] data,
	output logic              valid,
	output logic              match
);
	logic [ADDR_W-1:0] data_q;
	logic              valid_q;
	logic              match_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= prev_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (shift_en) begin
				valid_q <= prev_valid;
			end
			if (cmp_en) begin
				match_q <= valid_q && (data_q == cmp_addr);
			end
		end
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign match = match_q;
endmodule

@@ design/lmcmc_stack.sv @@
// Recency stack: a row of lmcmc_cell, most recent address in cell 0.
// Depends on lmcmc_pkg and lmcmc_cell.
module lmcmc_stack #(
	parameter int MAX_LINES = lmcmc_pkg::MAX_LINES_DEF,
	parameter int ADDR_W    = lmcmc_pkg::ADDR_BITS_DEF,
	localparam int POS_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lmcmc_pkg::stack_ctrl_t ctrl,
	input  logic                   cmp_en,
	input  logic [ADDR_W-1:0]      cmp_addr,
	input  logic [ADDR_W-1:0]      new_addr,
	output logic                   found,
	output logic [POS_W-1:0]       pos,
	output logic [MAX_LINES-1:0]   match_vec,
	output logic [MAX_LINES-1:0]   valid_vec
);
	import lmcmc_pkg::*;

	logic [ADDR_W-1:0]    data_w [MAX_LINES];
	logic [MAX_LINES-1:0] shift_w;
	logic                 found_c;
	logic [POS_W-1:0]     pos_c;
	logic                 found_q;
	logic [POS_W-1:0]     pos_q;

	for (genvar j = 0; j < MAX_LINES; j++) begin : g_cell
		logic [ADDR_W-1:0] prev_d;
		logic              prev_v;

		if (j == 0) begin : g_top
			assign prev_d = new_addr;
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_d = data_w[j-1];
			assign prev_v = valid_vec[j-1];
		end

		// on a hit only the cells up to the hit position move down
		assign shift_w[j] = ctrl.shift && (!found_q || (POS_W'(j) <= pos_q));

		lmcmc_cell #(.ADDR_W(ADDR_W)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (cmp_en),
			.cmp_addr   (cmp_addr),
			.shift_en   (shift_w[j]),
			.prev_data  (prev_d),
			.prev_valid (prev_v),
			.data       (data_w[j]),
			.valid      (valid_vec[j]),
			.match      (match_vec[j])
		);
	end

	// stored addresses are distinct, so at most one match: OR-encode it
	always_comb begin
		found_c = 1'b0;
		pos_c   = '0;
		for (int j = 0; j < MAX_LINES; j++) begin
			found_c = found_c | match_vec[j];
			pos_c   = pos_c | (match_vec[j] ? POS_W'(j) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			pos_q   <= '0;
		end else if (ctrl.encode) begin
			found_q <= found_c;
			pos_q   <= pos_c;
		end
	end

	assign found = found_q;
	assign pos   = pos_q;
endmodule

@@ design/lru_multi_cache_miss_counter_core.sv @@
// LRU multi-cache miss counter, top level: sequencer, config, miss counters, result register.
// An access is compared at acceptance, then its hit position is encoded, then the stack
// shifts and the counters update; a report goes straight to the update step. A request is
// taken only when idle; a result waits in its output register while the next request runs.
// Reset (arst_n low): stack valid bits, miss counters and control clear, config returns to
// num_caches 4 and all sizes 64. No clearing pass; ready right after reset.
module lru_multi_cache_miss_counter_core #(
	parameter int NUM_CACHES = lmcmc_pkg::NUM_CACHES_DEF,
	parameter int MAX_LINES  = lmcmc_pkg::MAX_LINES_DEF,
	parameter int ADDR_BITS  = lmcmc_pkg::ADDR_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lmcmc_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [lmcmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	lmcmc_req_if.sink                          req,
	lmcmc_res_if.source                        res
);
	import lmcmc_pkg::*;

	localparam int POS_W   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CMP_W   = (POS_W > SIZE_W) ? POS_W : SIZE_W;
	localparam int MAX_ACT = (NUM_CACHES < SLOTS) ? NUM_CACHES : SLOTS;

	typedef enum logic [1:0] {S_IDLE, S_ENC, S_UPD} state_t;

	state_t                state_q;
	logic                  type_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [NUMC_W-1:0]     num_caches_q;
	logic [SIZE_W-1:0]     size_q [SLOTS];
	logic [CNT_W-1:0]      cnt_q [SLOTS];
	logic [CNT_W-1:0]      cnt_nx [SLOTS];
	logic [CNT_W-1:0]      cnt_out [SLOTS];
	logic [CNT_W-1:0]      out_cnt_q [SLOTS];
	logic [SLOTS-1:0]      mask_c;
	logic [SLOTS-1:0]      out_mask_q;
	logic                  out_valid_q;
	logic [NUMC_W-1:0]     n_act;
	logic                  req_acc;
	logic                  upd_go;
	stack_ctrl_t           sctrl;
	logic                  found;
	logic [POS_W-1:0]      pos;
	logic [MAX_LINES-1:0]  match_vec;
	logic [MAX_LINES-1:0]  valid_vec;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign upd_go    = (state_q == S_UPD) && (!out_valid_q || res.ready);
	assign n_act     = (num_caches_q > NUMC_W'(MAX_ACT)) ? NUMC_W'(MAX_ACT) : num_caches_q;

	assign sctrl.encode = (state_q == S_ENC);
	assign sctrl.shift  = upd_go && (type_q == REQ_ACCESS);

	lmcmc_stack #(.MAX_LINES(MAX_LINES), .ADDR_W(ADDR_BITS)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (sctrl),
		.cmp_en    (req_acc && (req.req_type == REQ_ACCESS)),
		.cmp_addr  (req.address),
		.new_addr  (addr_q),
		.found     (found),
		.pos       (pos),
		.match_vec (match_vec),
		.valid_vec (valid_vec)
	);

	// cache i hits when the address sits above its capacity in the stack
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			logic act;
			logic miss;
			act  = (NUMC_W'(i) < n_act);
			miss = act && !(found && (CMP_W'(pos) < CMP_W'(size_q[i])));
			if (type_q == REQ_REPORT) begin
				mask_c[i]  = 1'b0;
				cnt_nx[i]  = '0;
				cnt_out[i] = act ? cnt_q[i] : '0;
			end else begin
				mask_c[i]  = miss;
				cnt_nx[i]  = (miss && (cnt_q[i] != '1)) ? cnt_q[i] + CNT_W'(1) : cnt_q[i];
				cnt_out[i] = act ? cnt_nx[i] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_q <= req.address;
		end
		if (upd_go) begin
			out_mask_q <= mask_c;
			for (int i = 0; i < SLOTS; i++) begin
				out_cnt_q[i] <= cnt_out[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			type_q       <= REQ_ACCESS;
			out_valid_q  <= 1'b0;
			num_caches_q <= NUM_CACHES_RST;
			for (int i = 0; i < SLOTS; i++) begin
				size_q[i] <= CACHE_SIZE_RST;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_CACHES:   num_caches_q <= cfg_wdata[NUMC_W-1:0];
					REG_CACHE_SIZE_0: size_q[0] <= cfg_wdata;
					REG_CACHE_SIZE_1: size_q[1] <= cfg_wdata;
					REG_CACHE_SIZE_2: size_q[2] <= cfg_wdata;
					REG_CACHE_SIZE_3: size_q[3] <= cfg_wdata;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						type_q  <= req.req_type;
						state_q <= (req.req_type == REQ_REPORT) ? S_UPD : S_ENC;
					end
				end
				S_ENC: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
						for (int i = 0; i < SLOTS; i++) begin
							cnt_q[i] <= cnt_nx[i];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.miss_mask    = out_mask_q;
	assign res.miss_count_0 = out_cnt_q[0];
	assign res.miss_count_1 = out_cnt_q[1];
	assign res.miss_count_2 = out_cnt_q[2];
	assign res.miss_count_3 = out_cnt_q[3];

	// stored addresses stay distinct
	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one stack cell matched");

	// valid entries form a contiguous run from the top of the stack
	a_valid_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + MAX_LINES'(1))) == '0))
		else $error("stack valid bits not contiguous");

	// a new result is loaded only from the update step
	a_res_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_UPD))
		else $error("result loaded outside update step");

	// a report never flags a miss
	a_report_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && (type_q == REQ_REPORT)) |=> (out_mask_q == '0))
		else $error("report result carries a miss mask");
endmodule
